// File: rtl/autorange_seven_segment_display_defines.svh
// Assertion macros shared by the display driver.
`ifndef AUTORANGE_SEVEN_SEGMENT_DISPLAY_DEFINES_SVH
`define AUTORANGE_SEVEN_SEGMENT_DISPLAY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ASSD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSD_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSD_ASSERT(lbl, clk, rst, prop, msg)
`define ASSD_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// File: rtl/assd_pkg.sv
package assd_pkg;

  localparam int SEG_W      = 8;
  localparam int NUM_DIGITS = 4;
  localparam int VALUE_W    = 25;
  localparam int MAG_W      = 24;
  localparam int NUM_W      = 14;

  localparam int DEFAULT_MID_DEPTH = 8;
  localparam int OUT_DEPTH         = 2;

  // Item kinds carried on the mode field.
  localparam logic MODE_VALUE = 1'b0;
  localparam logic MODE_SCAN  = 1'b1;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;

  localparam logic [VALUE_W-1:0] POS_MAX = 25'd9999999;
  localparam logic [VALUE_W-1:0] NEG_MAX = 25'd999999;

  // Exact reciprocals for 24-bit dividends: ceil(2^s / d), s = 24 + ceil(log2 d).
  localparam int SH_10   = 28;
  localparam int SH_100  = 31;
  localparam int SH_1000 = 34;
  localparam longint unsigned RECIP_10   = ((64'd1 << SH_10) + 64'd9) / 64'd10;
  localparam longint unsigned RECIP_100  = ((64'd1 << SH_100) + 64'd99) / 64'd100;
  localparam longint unsigned RECIP_1000 = ((64'd1 << SH_1000) + 64'd999) / 64'd1000;

  // The same for the 14-bit four-digit number.
  localparam int SQ_10   = 18;
  localparam int SQ_100  = 21;
  localparam int SQ_1000 = 24;
  localparam longint unsigned RQ_10   = ((64'd1 << SQ_10) + 64'd9) / 64'd10;
  localparam longint unsigned RQ_100  = ((64'd1 << SQ_100) + 64'd99) / 64'd100;
  localparam longint unsigned RQ_1000 = ((64'd1 << SQ_1000) + 64'd999) / 64'd1000;

  typedef logic [NUM_DIGITS-1:0][SEG_W-1:0] patterns_t;

  typedef struct packed {
    logic      scan;
    logic      upd;
    patterns_t pats;
  } cmd_t;

  typedef struct packed {
    logic                  accepted;
    logic [NUM_DIGITS-1:0] digit_enable;
    logic [SEG_W-1:0]      segments;
  } result_t;

  function automatic logic [SEG_W-1:0] seg_encode(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: rtl/autorange_seven_segment_display.sv
// Four-digit multiplexed seven-segment driver. Each item is either a new value in
// thousandths (mode 0) or a scan tick (mode 1), and yields exactly one result: the
// one-hot enable and segments of the scanned digit, with accepted set when a new
// value replaced the stored patterns. Positive values up to 9999.999 show on four
// digits with the decimal point placed after the integer part; negative values down
// to -999.999 show a minus sign and three digits; zero and out-of-range values leave
// the display as it was. One item is accepted every clock cycle while full is low. An
// item passes through three front pipeline stages (classification, one reciprocal
// multiplication for the scaling, digit quotients), the command queue, the stage that
// applies the item to the display state and the result queue. Full rises when the
// command queue plus the front pipeline hold MID_DEPTH items, and a two-entry result
// queue lets the state stage keep going while a result waits to be popped.
`include "autorange_seven_segment_display_defines.svh"

module autorange_seven_segment_display #(
  parameter int MID_DEPTH = assd_pkg::DEFAULT_MID_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                mode,
  input  logic signed [assd_pkg::VALUE_W-1:0] value_milli,
  output logic                                empty,
  input  logic                                pop,
  output logic                                accepted,
  output logic [assd_pkg::NUM_DIGITS-1:0]     digit_enable,
  output logic [assd_pkg::SEG_W-1:0]          segments
);

  localparam int CMD_W   = $bits(assd_pkg::cmd_t);
  localparam int RES_W   = $bits(assd_pkg::result_t);
  localparam int MCNT_W  = $clog2(MID_DEPTH + 1);
  localparam int OCNT_W  = $clog2(assd_pkg::OUT_DEPTH + 1);
  localparam int OCC_W   = MCNT_W + 2;

  logic               in_take;
  logic               front_valid;
  assd_pkg::cmd_t     front_cmd;
  logic [1:0]         inflight;

  logic [CMD_W-1:0]   mid_rdata;
  logic               mid_empty;
  logic [MCNT_W-1:0]  mid_count;
  logic [OCC_W-1:0]   occupancy;

  assd_pkg::cmd_t     back_cmd;
  logic               back_take;
  logic               res_space;
  assd_pkg::result_t  back_res;

  logic [RES_W-1:0]   out_rdata;
  logic [OCNT_W-1:0]  out_count;
  logic               out_pop;
  assd_pkg::result_t  out_res;

  assign in_take   = push && !full;
  assign occupancy = OCC_W'(mid_count) + OCC_W'(inflight);
  // Every item in the front pipeline already owns a place in the command queue.
  assign full      = occupancy >= OCC_W'(MID_DEPTH);

  assd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_take),
    .mode        (mode),
    .value_milli (value_milli),
    .out_valid   (front_valid),
    .cmd         (front_cmd),
    .inflight    (inflight)
  );

  assd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_cmd),
    .pop   (back_take),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  assign back_cmd  = assd_pkg::cmd_t'(mid_rdata);
  assign out_pop   = pop && !empty;
  assign res_space = (out_count < OCNT_W'(assd_pkg::OUT_DEPTH)) || out_pop;

  assd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!mid_empty),
    .cmd       (back_cmd),
    .res_space (res_space),
    .cmd_take  (back_take),
    .res       (back_res)
  );

  assd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (assd_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_take),
    .wdata (back_res),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (empty),
    .count (out_count)
  );

  assign out_res      = assd_pkg::result_t'(out_rdata);
  assign accepted     = out_res.accepted;
  assign digit_enable = out_res.digit_enable;
  assign segments     = out_res.segments;

  `ASSD_ASSERT(a_enable_onehot, clk, rst, !empty |-> $onehot(digit_enable), "digit enable not one-hot")
  `ASSD_NEVER(a_mid_credit, clk, rst, occupancy > OCC_W'(MID_DEPTH), "command queue overcommitted")
  `ASSD_NEVER(a_out_bound, clk, rst, out_count > OCNT_W'(assd_pkg::OUT_DEPTH), "result queue overflow")

endmodule

// File: rtl/assd_fifo.sv
module assd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic             do_pop;

  assign do_pop = pop && (count != '0);
  assign empty  = (count == '0);
  assign rdata  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/assd_front.sv
module assd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              mode,
  input  logic signed [assd_pkg::VALUE_W-1:0] value_milli,
  output logic                              out_valid,
  output assd_pkg::cmd_t                    cmd,
  output logic [1:0]                        inflight
);

  localparam int MW = assd_pkg::MAG_W;
  localparam int NW = assd_pkg::NUM_W;
  localparam int PW = 2 * MW + 1;
  localparam int QW = 2 * NW + 1;

  // Classification
  logic [assd_pkg::VALUE_W-1:0] bits_in;
  logic [assd_pkg::VALUE_W-1:0] mag25;
  logic                         neg;
  logic                         in_range;
  logic [1:0]                   ndig;

  logic          s1_valid, s1_scan, s1_upd, s1_neg;
  logic [1:0]    s1_exp;
  logic [MW-1:0] s1_mag;

  assign bits_in = value_milli;
  assign neg     = bits_in[assd_pkg::VALUE_W-1];
  assign mag25   = neg ? (assd_pkg::VALUE_W'(0) - bits_in) : bits_in;
  assign in_range = (bits_in != '0) &&
                    (neg ? (mag25 <= assd_pkg::NEG_MAX) : (mag25 <= assd_pkg::POS_MAX));

  always_comb begin
    if (mag25 < 25'd10000) begin
      ndig = 2'd0;
    end else if (mag25 < 25'd100000) begin
      ndig = 2'd1;
    end else if (mag25 < 25'd1000000) begin
      ndig = 2'd2;
    end else begin
      ndig = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  // The divisor exponent doubles as the decimal point position.
  always_ff @(posedge clk) begin
    s1_scan <= mode;
    s1_upd  <= !mode && in_range;
    s1_neg  <= neg;
    s1_exp  <= neg ? (ndig + 2'd1) : ndig;
    s1_mag  <= mag25[MW-1:0];
  end

  // Scaling by a power of ten through one reciprocal multiplication
  logic [MW:0]   recip;
  logic [PW-1:0] prod;
  logic [NW-1:0] n_scaled;

  logic          s2_valid, s2_scan, s2_upd, s2_neg;
  logic [1:0]    s2_dp;
  logic [NW-1:0] s2_n;

  always_comb begin
    unique case (s1_exp)
      2'd0:    recip = (MW+1)'(1);
      2'd1:    recip = (MW+1)'(assd_pkg::RECIP_10);
      2'd2:    recip = (MW+1)'(assd_pkg::RECIP_100);
      default: recip = (MW+1)'(assd_pkg::RECIP_1000);
    endcase
  end

  assign prod = PW'(s1_mag) * PW'(recip);

  always_comb begin
    unique case (s1_exp)
      2'd0:    n_scaled = prod[NW-1:0];
      2'd1:    n_scaled = prod[assd_pkg::SH_10 +: NW];
      2'd2:    n_scaled = prod[assd_pkg::SH_100 +: NW];
      default: n_scaled = prod[assd_pkg::SH_1000 +: NW];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_scan <= s1_scan;
    s2_upd  <= s1_upd;
    s2_neg  <= s1_neg;
    s2_dp   <= s1_exp;
    s2_n    <= n_scaled;
  end

  // Quotients of the four-digit number by ten, a hundred and a thousand
  logic [QW-1:0] p10, p100, p1000;

  logic          s3_valid, s3_scan, s3_upd, s3_neg;
  logic [1:0]    s3_dp;
  logic [NW-1:0] s3_n;
  logic [9:0]    s3_q1;
  logic [6:0]    s3_q2;
  logic [3:0]    s3_q3;

  assign p10   = QW'(s2_n) * QW'(assd_pkg::RQ_10);
  assign p100  = QW'(s2_n) * QW'(assd_pkg::RQ_100);
  assign p1000 = QW'(s2_n) * QW'(assd_pkg::RQ_1000);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_scan <= s2_scan;
    s3_upd  <= s2_upd;
    s3_neg  <= s2_neg;
    s3_dp   <= s2_dp;
    s3_n    <= s2_n;
    s3_q1   <= p10[assd_pkg::SQ_10 +: 10];
    s3_q2   <= p100[assd_pkg::SQ_100 +: 7];
    s3_q3   <= p1000[assd_pkg::SQ_1000 +: 4];
  end

  // Digits and segment patterns
  logic [3:0]          dig0, dig1, dig2;
  assd_pkg::patterns_t pats;
  logic [NW-1:0]       t0;
  logic [9:0]          t1;
  logic [6:0]          t2;

  assign t0   = s3_n - NW'(s3_q1) * NW'(10);
  assign t1   = s3_q1 - 10'(s3_q2) * 10'd10;
  assign t2   = s3_q2 - 7'(s3_q3) * 7'd10;
  assign dig0 = t0[3:0];
  assign dig1 = t1[3:0];
  assign dig2 = t2[3:0];

  always_comb begin
    pats[0] = s3_neg ? assd_pkg::SEG_MINUS : assd_pkg::seg_encode(s3_q3);
    pats[1] = assd_pkg::seg_encode(dig2);
    pats[2] = assd_pkg::seg_encode(dig1);
    pats[3] = assd_pkg::seg_encode(dig0);
    for (int k = 0; k < assd_pkg::NUM_DIGITS; k++) begin
      if (s3_dp == 2'(k)) begin
        pats[k] = pats[k] | assd_pkg::SEG_DP;
      end
    end
  end

  assign out_valid = s3_valid;
  assign cmd.scan  = s3_scan;
  assign cmd.upd   = s3_upd;
  assign cmd.pats  = pats;
  assign inflight  = {1'b0, s1_valid} + {1'b0, s2_valid} + {1'b0, s3_valid};

endmodule

// File: rtl/assd_back.sv
module assd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  assd_pkg::cmd_t    cmd,
  input  logic              res_space,
  output logic              cmd_take,
  output assd_pkg::result_t res
);

  assd_pkg::patterns_t patterns;
  assd_pkg::patterns_t patterns_next;
  logic [1:0]          scan_index;
  logic [1:0]          scan_index_next;

  assign cmd_take = cmd_valid && res_space;

  always_comb begin
    patterns_next   = patterns;
    scan_index_next = scan_index;
    if (cmd.scan) begin
      scan_index_next = scan_index + 2'd1;
    end else if (cmd.upd) begin
      patterns_next = cmd.pats;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      patterns   <= '0;
      scan_index <= '0;
    end else if (cmd_take) begin
      patterns   <= patterns_next;
      scan_index <= scan_index_next;
    end
  end

  // The result reflects the state after this item has taken effect.
  assign res.accepted     = !cmd.scan && cmd.upd;
  assign res.digit_enable = assd_pkg::NUM_DIGITS'(1) << scan_index_next;
  assign res.segments     = patterns_next[scan_index_next];

endmodule
